### hw/rtl/sbc_pkg.sv
package sbc_pkg;

    localparam int AMP_BITS_DEF = 24;
    localparam int FRQ_BITS     = 24;
    localparam int GAIN_BITS    = 17;
    localparam int GAIN_FRAC    = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC;

    // Operation codes of op_select.
    localparam logic [1:0] OP_SUM   = 2'd0;
    localparam logic [1:0] OP_DIFF  = 2'd1;
    localparam logic [1:0] OP_CROSS = 2'd2;
    localparam logic [1:0] OP_MAX   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_OP_SELECT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_USE_GAIN  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ALLOW_NEG = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN      = 2'd3;

endpackage

### hw/rtl/spectral_bin_combiner_core.sv
// Three stages lie between an input transfer and its result on the master side:
// operand prep, the amplitude-by-gain multiply, and rounding with combine and
// saturation. One channel is accepted per cycle while the output is not stalled.
// Back-pressure stalls stages only as far as needed; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and restores the
// registers: op_select sum, use_gain 0, allow_negative 0, gain 1.0.
module spectral_bin_combiner_core
    import sbc_pkg::*;
#(
    parameter int AMP_BITS = AMP_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]         i_cfg_addr,
    input  logic [GAIN_BITS-1:0]            i_cfg_wdata,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0 up: amp_a, frq_a, amp_b, frq_b, zero fill.
    input  logic [((2*AMP_BITS+2*FRQ_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                            s_axis_tlast,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0 up: amp_out, frq_out, zero fill.
    output logic [((AMP_BITS+FRQ_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);

    localparam int OUT_W = ((AMP_BITS + FRQ_BITS + 7) / 8) * 8;
    localparam int XW    = AMP_BITS + 1;
    localparam int PW    = XW + GAIN_BITS + 1;
    localparam int TW    = PW - GAIN_FRAC;
    localparam int RW    = AMP_BITS + 5;

    localparam logic [PW-1:0] RND = PW'(1) << (GAIN_FRAC - 1);
    localparam logic signed [RW-1:0] SAT_HI =
        $signed({{(RW-AMP_BITS+1){1'b0}}, {(AMP_BITS-1){1'b1}}});
    localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

    // Configuration registers.
    logic [1:0]           r_op;
    logic                 r_use_gain;
    logic                 r_allow_neg;
    logic [GAIN_BITS-1:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= OP_SUM;
            r_use_gain  <= 1'b0;
            r_allow_neg <= 1'b0;
            r_gain      <= GAIN_ONE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_OP_SELECT: r_op        <= i_cfg_wdata[1:0];
                REG_USE_GAIN:  r_use_gain  <= i_cfg_wdata[0];
                REG_ALLOW_NEG: r_allow_neg <= i_cfg_wdata[0];
                REG_GAIN:      r_gain      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage advance: a stage loads when it is empty or its contents move on.
    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3;

    assign w_en3         = !r_v3 || m_axis_tready;
    assign w_en2         = !r_v2 || w_en3;
    assign w_en1         = !r_v1 || w_en2;
    assign s_axis_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= s_axis_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    // Stage 1: unpack, form the multiplier operand, decide the maximum.
    logic signed [AMP_BITS-1:0] w_a, w_b;
    logic [FRQ_BITS-1:0]        w_fa, w_fb;
    logic signed [XW-1:0]       w_x;
    logic                       w_max_b;

    assign w_a  = $signed(s_axis_tdata[AMP_BITS-1:0]);
    assign w_fa = s_axis_tdata[AMP_BITS+FRQ_BITS-1:AMP_BITS];
    assign w_b  = $signed(s_axis_tdata[2*AMP_BITS+FRQ_BITS-1:AMP_BITS+FRQ_BITS]);
    assign w_fb = s_axis_tdata[2*AMP_BITS+2*FRQ_BITS-1:2*AMP_BITS+FRQ_BITS];
    assign w_max_b = w_b > w_a;

    always_comb begin
        if (r_op == OP_CROSS) begin
            w_x = XW'(w_b) - XW'(w_a);
        end else begin
            w_x = XW'(w_b);
        end
    end

    logic signed [AMP_BITS-1:0] r1_a, r1_b;
    logic signed [XW-1:0]       r1_x;
    logic [FRQ_BITS-1:0]        r1_f;
    logic                       r1_max_b, r1_last;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_a     <= w_a;
            r1_b     <= w_b;
            r1_x     <= w_x;
            r1_f     <= (r_op == OP_MAX && w_max_b) ? w_fb : w_fa;
            r1_max_b <= w_max_b;
            r1_last  <= s_axis_tlast;
        end
    end

    // Stage 2: scale by the unsigned Q1.16 gain.
    logic signed [PW-1:0] w_prod;
    assign w_prod = r1_x * $signed({1'b0, r_gain});

    logic signed [AMP_BITS-1:0] r2_a, r2_b;
    logic signed [PW-1:0]       r2_p;
    logic [FRQ_BITS-1:0]        r2_f;
    logic                       r2_max_b, r2_last;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_a     <= r1_a;
            r2_b     <= r1_b;
            r2_p     <= w_prod;
            r2_f     <= r1_f;
            r2_max_b <= r1_max_b;
            r2_last  <= r1_last;
        end
    end

    // Stage 3: round to nearest (ties up), combine, clip and saturate.
    logic [PW-1:0]          w_pr;
    logic signed [TW-1:0]   w_scaled;
    logic signed [RW-1:0]   w_ax, w_bx, w_term, w_r, w_sat;

    assign w_pr     = r2_p + RND;
    assign w_scaled = $signed(w_pr[PW-1:GAIN_FRAC]);
    assign w_ax     = RW'(r2_a);
    assign w_bx     = RW'(r2_b);
    assign w_term   = r_use_gain ? RW'(w_scaled) : w_bx;

    always_comb begin
        unique case (r_op)
            OP_SUM: begin
                w_r = w_ax + w_term;
            end
            OP_DIFF: begin
                w_r = w_ax - w_term;
                if (!r_allow_neg && w_r < 0) begin
                    w_r = '0;
                end
            end
            OP_CROSS: begin
                w_r = r_use_gain ? (w_ax + RW'(w_scaled)) : w_bx;
            end
            OP_MAX: begin
                w_r = r2_max_b ? w_bx : w_ax;
            end
            default: begin
                w_r = w_ax;
            end
        endcase

        if (w_r > SAT_HI) begin
            w_sat = SAT_HI;
        end else if (w_r < SAT_LO) begin
            w_sat = SAT_LO;
        end else begin
            w_sat = w_r;
        end
    end

    logic [AMP_BITS-1:0] r3_amp;
    logic [FRQ_BITS-1:0] r3_f;
    logic                r3_last;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_amp  <= w_sat[AMP_BITS-1:0];
            r3_f    <= r2_f;
            r3_last <= r2_last;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = OUT_W'({r3_f, r3_amp});
    assign m_axis_tlast  = r3_last;

endmodule

### hw/rtl/sbc_core_checker.sv
module sbc_core_checker
    import sbc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready
);

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A draining output leaves every stage free, so the input side never waits.
    a_ready_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    // With the output ready while it moves through, an accepted channel reaches the output as a valid result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid)
        else $error("result missing after pipeline latency");

    // A pending result is held until its transfer.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

endmodule

bind spectral_bin_combiner_core sbc_core_checker u_sbc_core_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
